// File: rtl/grid_local_max_detector_macros.svh
// Assertion macros shared by the grid local maximum detector RTL.
`ifndef GRID_LOCAL_MAX_DETECTOR_MACROS_SVH
`define GRID_LOCAL_MAX_DETECTOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GLMD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("grid_local_max_detector: assertion failed");
`define GLMD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("grid_local_max_detector: assertion failed");
`else
`define GLMD_ASSERT_IMP(label, clk, rst, ante, cons)
`define GLMD_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/gld_pkg.sv
// Shared types and constants of the grid local maximum detector.
`default_nettype none
package gld_pkg;
   localparam int CFG_BITS = 11;
   localparam int CSR_ADDR_BITS = 2;
   localparam int PEAK_BITS = 10;
   localparam int RSP_DATA_BITS = 24;
   localparam int RSP_PAD_BITS = RSP_DATA_BITS - 2 * PEAK_BITS;
   localparam int QUEUE_DEPTH = 4;
   localparam int SLOT_COUNT = 3;

   localparam logic [CSR_ADDR_BITS-1:0] REG_GRID_ROWS = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_GRID_COLS = 2'd1;

   // Position of the window's newest sample within the grid.
   typedef struct packed {
      logic has_up;
      logic has_up2;
      logic has_left;
      logic has_left2;
      logic last_col;
      logic last_row;
   } win_flags_type;

   // Peaks found for one sample: bit 0 is the centre one row above, bit 1 the
   // last-row centre to the left, bit 2 the bottom-right corner.
   typedef logic [SLOT_COUNT-1:0] peak_mask_type;
endpackage
`default_nettype wire

// File: rtl/gld_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gld_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// File: rtl/gld_front.sv
// Size registers, position counters, line store and the registered 4-neighbour window.
`default_nettype none
module gld_front #(
   parameter int MAX_COLS = 1024,
   parameter int MAX_ROWS = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_wr_en,
   input  wire logic [gld_pkg::CSR_ADDR_BITS-1:0]     csr_addr,
   input  wire logic [gld_pkg::CFG_BITS-1:0]          csr_wdata,
   input  wire logic                                  in_fire,
   input  wire logic signed [SAMPLE_BITS-1:0]         sample,
   output logic                                       win_valid,
   output gld_pkg::win_flags_type                     win_flags,
   output logic      [$clog2(MAX_ROWS)-1:0]           win_row,
   output logic      [$clog2(MAX_COLS)-1:0]           win_col,
   output logic signed [SAMPLE_BITS-1:0]              win_s,
   output logic signed [SAMPLE_BITS-1:0]              win_ctr,
   output logic signed [SAMPLE_BITS-1:0]              win_up2,
   output logic signed [SAMPLE_BITS-1:0]              win_ul,
   output logic signed [SAMPLE_BITS-1:0]              win_ur,
   output logic signed [SAMPLE_BITS-1:0]              win_left,
   output logic signed [SAMPLE_BITS-1:0]              win_left2
);
   localparam int ColW = $clog2(MAX_COLS);
   localparam int RowW = $clog2(MAX_ROWS);
   localparam int ColsW = $clog2(MAX_COLS + 1);
   localparam int RowsW = $clog2(MAX_ROWS + 1);
   localparam int CfgW = gld_pkg::CFG_BITS;
   localparam int ExtA = (ColsW > RowsW) ? ColsW : RowsW;
   localparam int ExtW = (ExtA > CfgW) ? ExtA : CfgW;
   localparam int PairW = 2 * SAMPLE_BITS;

   logic [RowsW-1:0] rows_ff, rows_in;
   logic [ColsW-1:0] cols_ff, cols_in;
   logic [RowW-1:0]  row_ff, row_in;
   logic [ColW-1:0]  col_ff, col_in;
   logic [ExtW-1:0]  wdata_ext, rows_lim, cols_lim;
   logic             cfg_hit;
   logic             last_col, last_row;
   logic [ColsW-1:0] col_nx_ext;
   logic [ColW-1:0]  raddr;
   logic [PairW-1:0] ram_q, rd_pair, wr_pair;
   logic             byp_ff, byp_in;
   logic [PairW-1:0] byp_data_ff;
   logic signed [SAMPLE_BITS-1:0] rd_line1, rd_line2;
   logic signed [SAMPLE_BITS-1:0] cent1_ff, cent2_ff, up_left_ff, left_ff, left2_ff;
   logic                          win_valid_ff;
   gld_pkg::win_flags_type        flags_in, win_flags_ff;
   logic [RowW-1:0]               win_row_ff;
   logic [ColW-1:0]               win_col_ff;
   logic signed [SAMPLE_BITS-1:0] win_s_ff, win_ctr_ff, win_up2_ff, win_ul_ff;
   logic signed [SAMPLE_BITS-1:0] win_ur_ff, win_left_ff, win_left2_ff;

   assign cfg_hit = csr_wr_en && (csr_addr == gld_pkg::REG_GRID_ROWS ||
                                  csr_addr == gld_pkg::REG_GRID_COLS);
   assign wdata_ext = ExtW'(csr_wdata);

   always_comb begin
      if (wdata_ext < ExtW'(2)) begin
         rows_lim = ExtW'(2);
      end else if (wdata_ext > ExtW'(MAX_ROWS)) begin
         rows_lim = ExtW'(MAX_ROWS);
      end else begin
         rows_lim = wdata_ext;
      end
      if (wdata_ext < ExtW'(2)) begin
         cols_lim = ExtW'(2);
      end else if (wdata_ext > ExtW'(MAX_COLS)) begin
         cols_lim = ExtW'(MAX_COLS);
      end else begin
         cols_lim = wdata_ext;
      end
   end

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_wr_en && csr_addr == gld_pkg::REG_GRID_ROWS) begin
         rows_in = RowsW'(rows_lim);
      end
      if (csr_wr_en && csr_addr == gld_pkg::REG_GRID_COLS) begin
         cols_in = ColsW'(cols_lim);
      end
   end

   assign last_col = (ColsW'(col_ff) + ColsW'(1)) == cols_ff;
   assign last_row = (RowsW'(row_ff) + RowsW'(1)) == rows_ff;

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (cfg_hit) begin
         row_in = '0;
         col_in = '0;
      end else if (in_fire) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // The line store is read one column ahead of the next sample, so the pair
   // for the right neighbour is ready when that sample arrives.
   assign col_nx_ext = ColsW'(col_in) + ColsW'(1);
   assign raddr = (col_nx_ext == cols_ff) ? '0 : ColW'(col_nx_ext);

   assign wr_pair = {cent1_ff, sample};
   assign byp_in = in_fire && (raddr == col_ff);
   assign rd_pair = byp_ff ? byp_data_ff : ram_q;
   assign rd_line1 = $signed(rd_pair[SAMPLE_BITS-1:0]);
   assign rd_line2 = $signed(rd_pair[PairW-1:SAMPLE_BITS]);

   gld_ram #(
      .WIDTH(PairW),
      .DEPTH(MAX_COLS)
   ) u_line (
      .clock(clock),
      .we   (in_fire),
      .waddr(col_ff),
      .wdata(wr_pair),
      .raddr(raddr),
      .rdata(ram_q)
   );

   always_comb begin
      flags_in.has_up    = row_ff != '0;
      flags_in.has_up2   = row_ff > RowW'(1);
      flags_in.has_left  = col_ff != '0;
      flags_in.has_left2 = col_ff > ColW'(1);
      flags_in.last_col  = last_col;
      flags_in.last_row  = last_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= RowsW'(2);
         cols_ff      <= ColsW'(2);
         row_ff       <= '0;
         col_ff       <= '0;
         byp_ff       <= 1'b0;
         win_valid_ff <= 1'b0;
      end else begin
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         byp_ff       <= byp_in;
         win_valid_ff <= in_fire;
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= wr_pair;
      if (in_fire) begin
         cent1_ff     <= rd_line1;
         cent2_ff     <= rd_line2;
         up_left_ff   <= cent1_ff;
         left2_ff     <= left_ff;
         left_ff      <= sample;
         win_flags_ff <= flags_in;
         win_row_ff   <= row_ff;
         win_col_ff   <= col_ff;
         win_s_ff     <= sample;
         win_ctr_ff   <= cent1_ff;
         win_up2_ff   <= cent2_ff;
         win_ul_ff    <= up_left_ff;
         win_ur_ff    <= rd_line1;
         win_left_ff  <= left_ff;
         win_left2_ff <= left2_ff;
      end
   end

   assign win_valid = win_valid_ff;
   assign win_flags = win_flags_ff;
   assign win_row   = win_row_ff;
   assign win_col   = win_col_ff;
   assign win_s     = win_s_ff;
   assign win_ctr   = win_ctr_ff;
   assign win_up2   = win_up2_ff;
   assign win_ul    = win_ul_ff;
   assign win_ur    = win_ur_ff;
   assign win_left  = win_left_ff;
   assign win_left2 = win_left2_ff;
endmodule
`default_nettype wire

// File: rtl/gld_decide.sv
// Neighbour comparisons that find the peaks decided by one window.
`default_nettype none
module gld_decide #(
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                          win_valid,
   input  wire gld_pkg::win_flags_type        win_flags,
   input  wire logic signed [SAMPLE_BITS-1:0] win_s,
   input  wire logic signed [SAMPLE_BITS-1:0] win_ctr,
   input  wire logic signed [SAMPLE_BITS-1:0] win_up2,
   input  wire logic signed [SAMPLE_BITS-1:0] win_ul,
   input  wire logic signed [SAMPLE_BITS-1:0] win_ur,
   input  wire logic signed [SAMPLE_BITS-1:0] win_left,
   input  wire logic signed [SAMPLE_BITS-1:0] win_left2,
   output gld_pkg::peak_mask_type             found,
   output logic                               grp_valid
);
   logic up_peak, left_peak, corner_peak;

   assign up_peak = win_flags.has_up && (win_ctr >= win_s) &&
                    (!win_flags.has_up2 || win_ctr >= win_up2) &&
                    (!win_flags.has_left || win_ctr >= win_ul) &&
                    (win_flags.last_col || win_ctr >= win_ur);

   assign left_peak = win_flags.last_row && win_flags.has_left &&
                      (win_left >= win_s) && (win_left >= win_ul) &&
                      (!win_flags.has_left2 || win_left >= win_left2);

   assign corner_peak = win_flags.last_row && win_flags.has_left && win_flags.last_col &&
                        (win_s >= win_ctr) && (win_s >= win_left);

   assign found = {corner_peak, left_peak, up_peak};
   assign grp_valid = win_valid && (found != '0);
endmodule
`default_nettype wire

// File: rtl/gld_queue.sv
// Result queue of peak groups and the serializer that sends one peak per transaction.
`default_nettype none
module gld_queue #(
   parameter int MAX_COLS = 1024,
   parameter int MAX_ROWS = 1024
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   push,
   input  wire gld_pkg::peak_mask_type                 push_mask,
   input  wire logic [$clog2(MAX_ROWS)-1:0]            push_row,
   input  wire logic [$clog2(MAX_COLS)-1:0]            push_col,
   output logic [$clog2(gld_pkg::QUEUE_DEPTH+1)-1:0]   count,
   output logic                                        out_valid,
   input  wire logic                                   out_ready,
   output logic [gld_pkg::PEAK_BITS-1:0]               peak_row,
   output logic [gld_pkg::PEAK_BITS-1:0]               peak_col,
   output logic                                        out_last
);
   localparam int ColW = $clog2(MAX_COLS);
   localparam int RowW = $clog2(MAX_ROWS);
   localparam int Depth = gld_pkg::QUEUE_DEPTH;
   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);
   localparam int PeakW = gld_pkg::PEAK_BITS;

   gld_pkg::peak_mask_type ent_mask_ff [Depth];
   logic [RowW-1:0]        ent_row_ff [Depth];
   logic [ColW-1:0]        ent_col_ff [Depth];
   logic [PtrW-1:0]        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]        count_ff, count_in;
   gld_pkg::peak_mask_type done_ff, done_in;
   gld_pkg::peak_mask_type rem, sel;
   logic [RowW-1:0]        head_row, row_sel;
   logic [ColW-1:0]        head_col, col_sel;
   logic [RowW+PeakW-1:0]  row_ext;
   logic [ColW+PeakW-1:0]  col_ext;
   logic                   fire, pop;

   assign out_valid = count_ff != '0;
   assign head_row = ent_row_ff[rd_ptr_ff];
   assign head_col = ent_col_ff[rd_ptr_ff];
   assign rem = ent_mask_ff[rd_ptr_ff] & ~done_ff;

   always_comb begin
      priority if (rem[0]) begin
         sel = gld_pkg::peak_mask_type'(1);
      end else if (rem[1]) begin
         sel = gld_pkg::peak_mask_type'(2);
      end else begin
         sel = gld_pkg::peak_mask_type'(4);
      end
   end

   always_comb begin
      row_sel = head_row;
      col_sel = head_col;
      if (sel[0]) begin
         row_sel = head_row - 1'b1;
      end else if (sel[1]) begin
         col_sel = head_col - 1'b1;
      end
   end

   assign out_last = (rem & ~sel) == '0;
   assign fire = out_valid && out_ready;
   assign pop = fire && out_last;

   assign row_ext = {{PeakW{1'b0}}, row_sel};
   assign col_ext = {{PeakW{1'b0}}, col_sel};
   assign peak_row = row_ext[PeakW-1:0];
   assign peak_col = col_ext[PeakW-1:0];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      done_in = done_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         done_in = '0;
      end else if (fire) begin
         done_in = done_ff | sel;
      end
      count_in = count_ff + CntW'(push) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         done_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_mask_ff[wr_ptr_ff] <= push_mask;
         ent_row_ff[wr_ptr_ff]  <= push_row;
         ent_col_ff[wr_ptr_ff]  <= push_col;
      end
   end

   assign count = count_ff;
endmodule
`default_nettype wire

// File: rtl/grid_local_max_detector.sv
// Top level of the streaming four-neighbour grid local maximum detector.
// Samples enter in raster order at up to one transaction per clock, and each
// peak (a sample not below any existing up, down, left or right neighbour)
// leaves as one result transaction carrying its row and column, with tlast on
// the final peak caused by one input sample. A sample is decided when the
// sample below it arrives; last-row samples are decided when their right
// neighbour arrives, so results are not in strict raster order. The window
// of an accepted sample is registered and its peaks are pushed into a
// four-entry result queue that sets the rate: outside the last row a sample
// yields at most one peak and one sample per clock is sustained while the
// result side is ready; in the last row a sample may yield up to three
// peaks, so the sustained rate there falls even with the result side always
// ready. The line store is one RAM of MAX_COLS words of two samples each,
// with one write and one registered read per clock; it needs no clearing
// after reset. Writing a size register restarts the grid at row 0, column 0;
// it is to be written only while the block is idle; the block does not enforce it.
`default_nettype none
`include "grid_local_max_detector_macros.svh"
module grid_local_max_detector #(
   parameter int MAX_COLS = 1024,
   parameter int MAX_ROWS = 1024,
   parameter int SAMPLE_BITS = 16,
   localparam int ReqBits = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [gld_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  wire logic [gld_pkg::CFG_BITS-1:0]        csr_wdata,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [ReqBits-1:0]                  req_tdata,  // sample
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [gld_pkg::RSP_DATA_BITS-1:0]        rsp_tdata,  // peak_col (high), peak_row (low)
   output logic                                     rsp_tlast
);
   localparam int ColW = $clog2(MAX_COLS);
   localparam int RowW = $clog2(MAX_ROWS);
   localparam int CntW = $clog2(gld_pkg::QUEUE_DEPTH + 1);

   logic                          in_fire;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          win_valid;
   gld_pkg::win_flags_type        win_flags;
   logic [RowW-1:0]               win_row;
   logic [ColW-1:0]               win_col;
   logic signed [SAMPLE_BITS-1:0] win_s, win_ctr, win_up2, win_ul, win_ur;
   logic signed [SAMPLE_BITS-1:0] win_left, win_left2;
   gld_pkg::peak_mask_type        found;
   logic                          grp_valid;
   logic [CntW-1:0]               q_count;
   logic [gld_pkg::PEAK_BITS-1:0] peak_row, peak_col;
   logic                          q_pop;
   logic                          q_room;

   assign sample = $signed(req_tdata[SAMPLE_BITS-1:0]);
   assign req_tready = ({1'b0, q_count} + (CntW + 1)'(win_valid)) <
                       (CntW + 1)'(gld_pkg::QUEUE_DEPTH);
   assign in_fire = req_tvalid && req_tready;

   gld_front #(
      .MAX_COLS   (MAX_COLS),
      .MAX_ROWS   (MAX_ROWS),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .csr_wr_en(csr_wr_en),
      .csr_addr (csr_addr),
      .csr_wdata(csr_wdata),
      .in_fire  (in_fire),
      .sample   (sample),
      .win_valid(win_valid),
      .win_flags(win_flags),
      .win_row  (win_row),
      .win_col  (win_col),
      .win_s    (win_s),
      .win_ctr  (win_ctr),
      .win_up2  (win_up2),
      .win_ul   (win_ul),
      .win_ur   (win_ur),
      .win_left (win_left),
      .win_left2(win_left2)
   );

   gld_decide #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_decide (
      .win_valid(win_valid),
      .win_flags(win_flags),
      .win_s    (win_s),
      .win_ctr  (win_ctr),
      .win_up2  (win_up2),
      .win_ul   (win_ul),
      .win_ur   (win_ur),
      .win_left (win_left),
      .win_left2(win_left2),
      .found    (found),
      .grp_valid(grp_valid)
   );

   gld_queue #(
      .MAX_COLS(MAX_COLS),
      .MAX_ROWS(MAX_ROWS)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (grp_valid),
      .push_mask(found),
      .push_row (win_row),
      .push_col (win_col),
      .count    (q_count),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .peak_row (peak_row),
      .peak_col (peak_col),
      .out_last (rsp_tlast)
   );

   assign rsp_tdata = {{gld_pkg::RSP_PAD_BITS{1'b0}}, peak_col, peak_row};

   assign q_pop = rsp_tvalid && rsp_tready && rsp_tlast && !grp_valid;
   assign q_room = q_count < CntW'(gld_pkg::QUEUE_DEPTH);

   `GLMD_ASSERT_NXT(a_accept_loads_window, clock, reset, in_fire, win_valid)
   `GLMD_ASSERT_IMP(a_push_has_room, clock, reset, grp_valid, q_room)
   `GLMD_ASSERT_NXT(a_pop_frees_entry, clock, reset, q_pop, q_count == $past(q_count) - CntW'(1))
endmodule
`default_nettype wire
